### rtl/lphm_pkg.sv
// Package for the linear-probe hash map: sizes, command codes, hash helper.
// No dependencies.
package lphm_pkg;
    localparam int Capacity   = 256;
    localparam int SlotW      = $clog2(Capacity);
    localparam int KeyW       = 32;
    localparam int ValW       = 32;
    localparam int CountW     = 8;
    localparam int Threshold  = (Capacity / 4) * 3;
    localparam logic [31:0] MultReset = 32'd2654435761;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Memory entry: key and value share one word.
    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [ValW-1:0] val;
    } t_entry;

    // Result item; packed so found is the lowest bit.
    typedef struct packed {
        logic [CountW-1:0] entry_count;
        logic              full_reject;
        logic              was_new;
        logic [SlotW-1:0]  slot;
        logic [ValW-1:0]   read_value;
        logic              found;
    } t_result;

    // Home slot: top bits of the low 32 product bits.
    function automatic logic [SlotW-1:0] home_of(input logic [63:0] prod);
        return prod[31 -: SlotW];
    endfunction
endpackage

### rtl/linear_probe_hash_map_unit.sv
// Top level of the linear-probe hash map with backward-shift deletion.
// Depends on lphm_pkg and lphm_hash.
//
// One command item at a time (lookup, insert/update, erase, clear) against a 256-slot table
// held in a synchronous key/value memory with a registered read, plus a flip-flop valid bit
// per slot. An item is accepted in idle. It then goes through the hash state and the compare
// state, which stays on for each further probed slot, because the read of the next slot
// overlaps the compare of the current one. An erase then walks the rest of the cluster: each
// occupied slot passes through read, hash and decide, and the empty slot that ends it through
// read alone. The result register is then loaded, and the block returns to idle. A clear
// skips hash and probe. The result register keeps the two sides apart: the next item is
// accepted while a result waits. Its walk then holds before the load until the earlier
// result is taken.
module linear_probe_hash_map_unit
    import lphm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [31:0] key, [63:32] value
    input  logic [63:0] s_axis_tdata,
    // tuser: [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: found, read_value[32], slot[8], was_new, full_reject, entry_count[8]; 51 bits
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HASH  = 8'b0000_0010,  // product registered, home ready
        S_PRD   = 8'b0000_0100,  // probe read issued
        S_PCMP  = 8'b0000_1000,  // compare probe data
        S_ERD   = 8'b0001_0000,  // erase walk: read slot j
        S_EH1   = 8'b0010_0000,  // hash of entry at j
        S_EH2   = 8'b0100_0000,  // decide shift
        S_DONE  = 8'b1000_0000   // wait for output register
    } t_state;

    t_state r_state, n_state;
    logic [31:0]       r_mult;
    logic [Capacity-1:0] r_valid;
    logic [CountW-1:0] r_count;
    t_cmd              r_cmd;
    logic [KeyW-1:0]   r_key;
    logic [ValW-1:0]   r_val;
    logic [SlotW-1:0]  r_idx, r_gap;
    logic              r_ovld;
    t_result           r_work;
    t_result           r_out;

    t_entry mem [Capacity];
    t_entry r_rd;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    t_entry           wr_data;

    logic [KeyW-1:0]  hash_key;
    logic [SlotW-1:0] home;

    lphm_hash u_hash (
        .i_clk  (i_clk),
        .i_key  (hash_key),
        .i_mult (r_mult),
        .o_home (home)
    );

    // Hash the incoming key, or the key just read during an erase walk.
    assign hash_key = (r_state == S_IDLE) ? s_axis_tdata[31:0] : r_rd.key;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = 56'(r_out);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // Cyclic "k lies in (i, j]" test for the backward shift.
    logic stay;
    always_comb begin
        if (r_idx > r_gap) stay = (home > r_gap) && (home <= r_idx);
        else               stay = (home > r_gap) || (home <= r_idx);
    end

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_gap;
        wr_data = r_rd;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (t_cmd'(s_axis_tuser) == CMD_CLEAR) ? S_DONE : S_HASH;
                end
            end
            S_HASH: begin
                rd_addr = home;
                n_state = S_PCMP;
            end
            S_PRD:  n_state = S_PCMP;
            S_PCMP: begin
                if (!r_valid[r_idx] || r_rd.key != r_key) begin
                    if (!r_valid[r_idx]) begin
                        n_state = S_DONE;
                        if (r_cmd == CMD_INSERT && r_count < CountW'(Threshold)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_idx;
                            wr_data = '{key: r_key, val: r_val};
                        end
                    end else begin
                        rd_addr = r_idx + 1'b1;
                        n_state = S_PCMP;
                    end
                end else begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_idx;
                            wr_data = '{key: r_key, val: r_val};
                            n_state = S_DONE;
                        end
                        CMD_ERASE: begin
                            rd_addr = r_idx + 1'b1;
                            n_state = S_ERD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ERD: begin
                n_state = r_valid[r_idx] ? S_EH1 : S_DONE;
            end
            S_EH1: n_state = S_EH2;
            S_EH2: begin
                if (!stay) begin
                    wr_en   = 1'b1;
                    wr_addr = r_gap;
                    wr_data = r_rd;
                end
                rd_addr = r_idx + 1'b1;
                n_state = S_ERD;
            end
            S_DONE: if (!r_ovld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic found_now;
    assign found_now = r_valid[r_idx] && r_rd.key == r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mult  <= MultReset;
            r_valid <= '0;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_mult <= i_cfg_data;
            if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd  <= t_cmd'(s_axis_tuser);
                        r_key  <= s_axis_tdata[31:0];
                        r_val  <= s_axis_tdata[63:32];
                        r_work <= '0;
                        if (t_cmd'(s_axis_tuser) == CMD_CLEAR) begin
                            r_valid <= '0;
                            r_count <= '0;
                        end
                    end
                end
                S_HASH: r_idx <= home;
                S_PCMP: begin
                    if (found_now) begin
                        r_work.found <= 1'b1;
                        r_work.slot  <= r_idx;
                        if (r_cmd == CMD_LOOKUP) r_work.read_value <= r_rd.val;
                        if (r_cmd == CMD_ERASE) begin
                            r_gap   <= r_idx;
                            r_idx   <= r_idx + 1'b1;
                            r_count <= r_count - 1'b1;
                        end
                    end else if (!r_valid[r_idx]) begin
                        if (r_cmd == CMD_INSERT) begin
                            if (r_count < CountW'(Threshold)) begin
                                r_valid[r_idx] <= 1'b1;
                                r_count        <= r_count + 1'b1;
                                r_work.slot    <= r_idx;
                                r_work.was_new <= 1'b1;
                            end else begin
                                r_work.full_reject <= 1'b1;
                            end
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ERD: if (!r_valid[r_idx]) r_valid[r_gap] <= 1'b0;
                S_EH2: begin
                    if (!stay) r_gap <= r_idx;
                    r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    // Hold until the earlier result is taken, then load this one.
                    if (!r_ovld) begin
                        r_ovld <= 1'b1;
                        r_out  <= '{entry_count: r_count,
                                    full_reject: r_work.full_reject,
                                    was_new:     r_work.was_new,
                                    slot:        r_work.slot,
                                    read_value:  r_work.read_value,
                                    found:       r_work.found};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/lphm_hash.sv
// Registered multiplicative hash: one multiply, with the product registered before the home slot is taken from it.
// Depends on lphm_pkg.
module lphm_hash (
    input  logic                          i_clk,
    input  logic [lphm_pkg::KeyW-1:0]     i_key,
    input  logic [31:0]                   i_mult,
    output logic [lphm_pkg::SlotW-1:0]    o_home
);
    import lphm_pkg::*;
    logic [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_key) * 64'(i_mult);
    end
    assign o_home = home_of(r_prod);
endmodule

### rtl/lphm_checker.sv
// Port-level checks for linear_probe_hash_map_unit, attached by bind.
// Depends on lphm_pkg.
module lphm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    import lphm_pkg::*;
    t_result res;
    assign res = t_result'(m_axis_tdata[50:0]);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.entry_count <= CountW'(Threshold))
        else $error("count above load limit");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(res.was_new && (res.found || res.full_reject)))
        else $error("inconsistent insert flags");
endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (.*);

### dv/tb.sv
// Testbench for linear_probe_hash_map_unit: drives command items over the stream ports,
// predicts each result with its own table model and checks it field by field.
// Depends on lphm_pkg and the RTL of the block.
module tb;
    import lphm_pkg::*;

    // Table model and result queue
    class hash_table_board;
        bit              occupied [Capacity];
        bit [KeyW-1:0]   keys [Capacity];
        bit [ValW-1:0]   vals [Capacity];
        int unsigned     count;
        bit [31:0]       mult;
        t_result         pending [$];
        int unsigned     errors;

        function new();
            mult = MultReset;
            count = 0;
            errors = 0;
            foreach (occupied[i]) occupied[i] = 0;
        endfunction

        function int unsigned home(bit [KeyW-1:0] k);
            bit [63:0] prod;
            prod = {32'd0, k} * {32'd0, mult};
            return prod[31 -: SlotW];
        endfunction

        // Walk from home to the key or the first empty slot.
        function bit search(bit [KeyW-1:0] k, output int unsigned where);
            int unsigned idx;
            idx = home(k);
            for (int s = 0; s < Capacity; s++) begin
                if (!occupied[idx]) break;
                if (keys[idx] == k) begin
                    where = idx;
                    return 1;
                end
                idx = (idx + 1) % Capacity;
            end
            where = idx;
            return 0;
        endfunction

        // Close the gap by shifting later cluster members back.
        function void shift_out(int unsigned gap);
            int unsigned i, j, h;
            i = gap;
            j = gap;
            for (int s = 0; s < Capacity; s++) begin
                j = (j + 1) % Capacity;
                if (!occupied[j]) break;
                h = home(keys[j]);
                if ((j > i && (h <= i || h > j)) || (j < i && h <= i && h > j)) begin
                    keys[i] = keys[j];
                    vals[i] = vals[j];
                    i = j;
                end
            end
            occupied[i] = 0;
        endfunction

        function void note_item(t_cmd c, bit [KeyW-1:0] k, bit [ValW-1:0] v);
            t_result r;
            int unsigned where;
            bit hit;
            r = '0;
            if (c == CMD_CLEAR) begin
                foreach (occupied[i]) occupied[i] = 0;
                count = 0;
            end else begin
                hit = search(k, where);
                r.found = hit;
                case (c)
                    CMD_LOOKUP: begin
                        if (hit) begin
                            r.read_value = vals[where];
                            r.slot = SlotW'(where);
                        end
                    end
                    CMD_INSERT: begin
                        if (hit) begin
                            vals[where] = v;
                            r.slot = SlotW'(where);
                        end else if (count >= Threshold || occupied[where]) begin
                            r.full_reject = 1;
                        end else begin
                            occupied[where] = 1;
                            keys[where] = k;
                            vals[where] = v;
                            count++;
                            r.slot = SlotW'(where);
                            r.was_new = 1;
                        end
                    end
                    default: begin
                        if (hit) begin
                            r.slot = SlotW'(where);
                            shift_out(where);
                            if (count > 0) count--;
                        end
                    end
                endcase
            end
            r.entry_count = CountW'(count);
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.found != exp_r.found) begin
                $error("found exp %0d got %0d", exp_r.found, got.found); errors++;
            end
            if (got.read_value != exp_r.read_value) begin
                $error("read_value exp %h got %h", exp_r.read_value, got.read_value);
                errors++;
            end
            if (got.slot != exp_r.slot) begin
                $error("slot exp %0d got %0d", exp_r.slot, got.slot); errors++;
            end
            if (got.was_new != exp_r.was_new) begin
                $error("was_new exp %0d got %0d", exp_r.was_new, got.was_new); errors++;
            end
            if (got.full_reject != exp_r.full_reject) begin
                $error("full_reject exp %0d got %0d", exp_r.full_reject, got.full_reject);
                errors++;
            end
            if (got.entry_count != exp_r.entry_count) begin
                $error("entry_count exp %0d got %0d", exp_r.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit [KeyW-1:0] key_pool [16];
    hash_table_board board = new();

    linear_probe_hash_map_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: stall at random, check each taken item.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drop valid only while idling, so back-to-back items keep it high.
    task automatic send_item(t_cmd c, bit [KeyW-1:0] k, bit [ValW-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= c;
        s_axis_tdata <= {v, k};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(c, k, v);
    endtask

    // Write the multiplier only once the block is drained.
    task automatic write_mult(bit [31:0] m);
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.mult = m;
        i_cfg_valid <= 0;
    endtask

    function automatic bit [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom;
            default: return key_pool[$urandom_range(15)];
        endcase
    endfunction

    // Random phase: a random mix of inserts, lookups, erases and clears.
    task automatic random_phase(int n, int unsigned idle, int unsigned stall);
        t_cmd c;
        int unsigned r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45)      c = CMD_INSERT;
            else if (r < 70) c = CMD_LOOKUP;
            else if (r < 98) c = CMD_ERASE;
            else             c = CMD_CLEAR;
            send_item(c, (c == CMD_INSERT && $urandom_range(1)) ? $urandom : pick_key(),
                      $urandom);
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, every command, absent erase, clear.
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_ERASE, '1, '0);
        send_item(CMD_INSERT, '0, '1);
        send_item(CMD_INSERT, '1, '0);
        send_item(CMD_INSERT, '1, 32'h5a5a_a5a5);
        send_item(CMD_LOOKUP, '1, '0);
        send_item(CMD_LOOKUP, '0, '0);
        for (int i = 1; i <= 6; i++) send_item(CMD_INSERT, i << 24, i);
        send_item(CMD_ERASE, 1 << 24, '0);
        send_item(CMD_LOOKUP, 3 << 24, '0);
        send_item(CMD_ERASE, '0, '0);
        send_item(CMD_CLEAR, '1, '1);
        send_item(CMD_LOOKUP, '1, '0);

        // Fill to the load limit and beyond to hit the refusal.
        write_mult(32'd1);
        for (int i = 0; i < Threshold + 3; i++) send_item(CMD_INSERT, $urandom, $urandom);
        send_item(CMD_INSERT, key_pool[2], '1);
        random_phase(60, 0, 0);
        send_item(CMD_CLEAR, '0, '0);

        write_mult(32'hFFFF_FFFF);
        random_phase(90, 0, 0);
        write_mult(MultReset);
        random_phase(100, 77, 0);
        write_mult($urandom | 32'd1);
        random_phase(100, 0, 77);
        random_phase(85, 17, 17);

        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (board.errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("tb: errors");
        $finish;
    end
endmodule
